// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, quiet while reset is low
`define CHK_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge, quiet while reset is low
`define CHK_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// implication whose consequent is checked at the next rising edge
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// types, constants and helpers of the byte stream diff range block
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam int unsigned MAX_LEN = 65536;
	localparam int POS_W = 17;
	localparam int OFF_W = 16;
	localparam int CNT_W = 17;
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	localparam logic [OFF_W-1:0] BANK1_BASE = 16'h2000;
	localparam logic [OFF_W-1:0] BANK2_BASE = 16'h4000;
	localparam logic [OFF_W-1:0] BANK3_BASE = 16'h6000;

	// input commands
	localparam logic CMD_CMP = 1'b0;
	localparam logic CMD_FIN = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_DIFF    = 2'd0;
	localparam logic [1:0] KIND_EQUAL   = 2'd1;
	localparam logic [1:0] KIND_SIZE    = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	// bank regions
	localparam logic [1:0] REGION_0 = 2'd0;
	localparam logic [1:0] REGION_1 = 2'd1;
	localparam logic [1:0] REGION_2 = 2'd2;
	localparam logic [1:0] REGION_3 = 2'd3;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       left_byte;
		logic [7:0]       right_byte;
		logic [CNT_W-1:0] left_size;
		logic [CNT_W-1:0] right_size;
	} item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [OFF_W-1:0] range_start;
		logic [OFF_W-1:0] range_end;
		logic [1:0]       region;
		logic             identical;
		logic [CNT_W-1:0] differing_count;
		logic [CNT_W-1:0] equal_count;
		logic [OFF_W-1:0] first_diff;
		logic [OFF_W-1:0] last_diff;
		logic             overflow;
		logic             last_result;
	} result_t;

	// work handed from the front to the back
	typedef struct packed {
		logic             fin;
		logic             run_vld;
		logic [1:0]       run_kind;
		logic [OFF_W-1:0] run_start;
		logic [OFF_W-1:0] run_end;
		logic             size_diff;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic [POS_W-1:0] tail;
		logic [CNT_W-1:0] diff_total;
		logic [OFF_W-1:0] first_seen;
		logic [OFF_W-1:0] last_seen;
		logic             ovf;
	} job_t;

	typedef enum logic [1:0] {
		STEP_RUN,
		STEP_TAIL,
		STEP_SUM
	} step_e;

	function automatic logic [1:0] region_of(input logic [OFF_W-1:0] off);
		logic [1:0] r;
		if (off < BANK1_BASE) r = REGION_0;
		else if (off < BANK2_BASE) r = REGION_1;
		else if (off < BANK3_BASE) r = REGION_2;
		else r = REGION_3;
		return r;
	endfunction

endpackage

// ===== src/bsd_front.sv =====
// ----------------------------------------------------------------------------
// bsd_front
// takes items, tracks position and run state, issues range and finish jobs
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  jq_full,
	output logic  jq_push,
	output job_t  jq_job
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic             in_diff_q, in_diff_d;
	logic             in_eq_q, in_eq_d;
	logic [OFF_W-1:0] run_start_q, run_start_d;
	logic [CNT_W-1:0] diff_total_q, diff_total_d;
	logic [OFF_W-1:0] first_q, first_d;
	logic [OFF_W-1:0] last_q, last_d;
	logic             ovf_q, ovf_d;

	logic             accept;
	logic             is_diff;
	logic [POS_W-1:0] pos_m1;
	logic [CNT_W-1:0] ls_sat, rs_sat, lo, hi;

	assign full    = jq_full;
	assign accept  = push && !jq_full;
	assign is_diff = item.left_byte != item.right_byte;
	assign pos_m1  = pos_q - POS_W'(1);

	// sizes clamp to capacity
	assign ls_sat = (item.left_size > MAX_POS) ? MAX_POS : item.left_size;
	assign rs_sat = (item.right_size > MAX_POS) ? MAX_POS : item.right_size;
	assign lo     = (ls_sat < rs_sat) ? ls_sat : rs_sat;
	assign hi     = (ls_sat < rs_sat) ? rs_sat : ls_sat;

	always_comb begin
		pos_d        = pos_q;
		in_diff_d    = in_diff_q;
		in_eq_d      = in_eq_q;
		run_start_d  = run_start_q;
		diff_total_d = diff_total_q;
		first_d      = first_q;
		last_d       = last_q;
		ovf_d        = ovf_q;
		jq_push      = 1'b0;
		jq_job       = '0;

		jq_job.run_start = run_start_q;
		jq_job.run_end   = pos_m1[OFF_W-1:0];

		if (accept) begin
			if (item.cmd == CMD_FIN) begin
				jq_push           = 1'b1;
				jq_job.fin        = 1'b1;
				jq_job.run_vld    = (pos_q != '0) && (in_diff_q || in_eq_q);
				jq_job.run_kind   = in_diff_q ? KIND_DIFF : KIND_EQUAL;
				jq_job.size_diff  = ls_sat != rs_sat;
				jq_job.lo         = lo;
				jq_job.hi         = hi;
				jq_job.tail       = hi - lo;
				jq_job.diff_total = diff_total_q;
				jq_job.first_seen = first_q;
				jq_job.last_seen  = last_q;
				jq_job.ovf        = ovf_q;
				// back to the reset state
				pos_d        = '0;
				in_diff_d    = 1'b0;
				in_eq_d      = 1'b0;
				run_start_d  = '0;
				diff_total_d = '0;
				first_d      = '0;
				last_d       = '0;
				ovf_d        = 1'b0;
			end else if (pos_q >= MAX_POS) begin
				ovf_d = 1'b1;
			end else begin
				pos_d = pos_q + POS_W'(1);
				if (is_diff) begin
					if (diff_total_q == '0) first_d = pos_q[OFF_W-1:0];
					last_d = pos_q[OFF_W-1:0];
					if (diff_total_q != CNT_SAT) diff_total_d = diff_total_q + CNT_W'(1);
					if (in_eq_q) begin
						jq_push         = 1'b1;
						jq_job.run_vld  = 1'b1;
						jq_job.run_kind = KIND_EQUAL;
						in_eq_d         = 1'b0;
					end
					if (!in_diff_q) begin
						in_diff_d   = 1'b1;
						run_start_d = pos_q[OFF_W-1:0];
					end
				end else begin
					if (in_diff_q) begin
						jq_push         = 1'b1;
						jq_job.run_vld  = 1'b1;
						jq_job.run_kind = KIND_DIFF;
						in_diff_d       = 1'b0;
					end
					if (!in_eq_q) begin
						in_eq_d     = 1'b1;
						run_start_d = pos_q[OFF_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			in_diff_q    <= 1'b0;
			in_eq_q      <= 1'b0;
			run_start_q  <= '0;
			diff_total_q <= '0;
			first_q      <= '0;
			last_q       <= '0;
			ovf_q        <= 1'b0;
		end else begin
			pos_q        <= pos_d;
			in_diff_q    <= in_diff_d;
			in_eq_q      <= in_eq_d;
			run_start_q  <= run_start_d;
			diff_total_q <= diff_total_d;
			first_q      <= first_d;
			last_q       <= last_d;
			ovf_q        <= ovf_d;
		end
	end

endmodule

// ===== src/bsd_job_q.sv =====
// ----------------------------------------------------------------------------
// bsd_job_q
// short queue of jobs between the front and the back
// ----------------------------------------------------------------------------
module bsd_job_q import bsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  job_t   wr_job,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output job_t   rd_job
);

	job_t                 slot_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [JOBQ_AW:0]     cnt_q;
	logic                 do_wr, do_rd;

	assign full   = cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = slot_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (JOBQ_AW+1)'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - (JOBQ_AW+1)'(1);
		end
	end

endmodule

// ===== src/bsd_back.sv =====
// ----------------------------------------------------------------------------
// bsd_back
// expands jobs into result items and holds them in a two-entry output queue
// ----------------------------------------------------------------------------
module bsd_back import bsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_empty,
	input  job_t    job,
	output logic    jq_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	step_e step_q, step_d, eff_step;

	result_t res;
	logic    emit, job_done;

	logic [CNT_W:0]   sum_w;
	logic [CNT_W-1:0] differing, equal;
	logic [POS_W-1:0] hi_m1;
	logic [OFF_W-1:0] first_sel, last_sel;

	// two-entry output queue
	result_t    oq_q [2];
	logic       oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_full, do_pop;

	assign oq_full = oq_cnt_q == 2'd2;
	assign empty   = oq_cnt_q == 2'd0;
	assign result  = oq_q[oq_rd_q];
	assign do_pop  = pop && !empty;

	// skip the steps a finish job has no result for
	always_comb begin
		if (!job.fin) begin
			eff_step = STEP_RUN;
		end else begin
			unique case (step_q)
				STEP_RUN:  eff_step = job.run_vld ? STEP_RUN :
					(job.size_diff ? STEP_TAIL : STEP_SUM);
				STEP_TAIL: eff_step = job.size_diff ? STEP_TAIL : STEP_SUM;
				default:   eff_step = STEP_SUM;
			endcase
		end
	end

	assign emit     = !job_empty && !oq_full;
	assign job_done = !job.fin || (eff_step == STEP_SUM);
	assign jq_pop   = emit && job_done;

	// next step
	always_comb begin
		step_d = step_q;
		if (emit) begin
			if (job_done) step_d = STEP_RUN;
			else if (eff_step == STEP_RUN) step_d = STEP_TAIL;
			else step_d = STEP_SUM;
		end
	end

	// summary arithmetic
	assign sum_w     = {1'b0, job.diff_total} + (job.size_diff ? {1'b0, job.tail} : '0);
	assign differing = sum_w[CNT_W] ? CNT_SAT : sum_w[CNT_W-1:0];
	assign equal     = (differing > job.hi) ? '0 : job.hi - differing;
	assign hi_m1     = job.hi - POS_W'(1);
	assign first_sel = (job.size_diff && job.diff_total == '0) ? job.lo[OFF_W-1:0]
		: job.first_seen;
	assign last_sel  = job.size_diff ? hi_m1[OFF_W-1:0] : job.last_seen;

	// result of the current step
	always_comb begin
		res = '0;
		unique case (eff_step)
			STEP_RUN: begin
				res.result_kind = job.run_kind;
				res.range_start = job.run_start;
				res.range_end   = job.run_end;
				res.region      = (job.run_kind == KIND_DIFF) ? region_of(job.run_start)
					: REGION_0;
				res.last_result = !job.fin;
			end
			STEP_TAIL: begin
				res.result_kind = KIND_SIZE;
				res.range_start = job.lo[OFF_W-1:0];
				res.range_end   = hi_m1[OFF_W-1:0];
				res.region      = region_of(job.lo[OFF_W-1:0]);
			end
			default: begin
				res.result_kind     = KIND_SUMMARY;
				res.identical       = differing == '0;
				res.differing_count = differing;
				res.equal_count     = equal;
				res.first_diff      = (differing == '0) ? '0 : first_sel;
				res.last_diff       = (differing == '0) ? '0 : last_sel;
				res.overflow        = job.ovf;
				res.last_result     = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) oq_q[oq_wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RUN;
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			step_q <= step_d;
			if (emit) oq_wr_q <= !oq_wr_q;
			if (do_pop) oq_rd_q <= !oq_rd_q;
			if (emit && !do_pop) oq_cnt_q <= oq_cnt_q + 2'd1;
			else if (do_pop && !emit) oq_cnt_q <= oq_cnt_q - 2'd1;
		end
	end

endmodule

// ===== src/byte_stream_diff_ranges.sv =====
// ----------------------------------------------------------------------------
// byte_stream_diff_ranges
// compares two byte streams and reports differing and equal ranges
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive item and raise push; the item is taken on a
//   rising edge with push high and full low. cmd compare carries one byte pair,
//   cmd finish carries both image sizes and closes the comparison
//   result side is a queue: while empty is low the oldest result item is on
//   result; it is taken on a rising edge with pop high and empty low
//   a compare item gives at most one range item; a finish item gives the open
//   run, an optional size tail range and a summary, last_result marks the end
//   a taken item's job is registered in the job queue, its result items then in
//   the output queue. The front takes one compare item per cycle while the job
//   queue is not full; the back gives a finish item's one to three result items
//   in turn while the output queue has room. A four-entry job queue sits between
//   the front (run tracking) and the back (result generation), a two-entry output
//   queue follows the back, so a stalled receiver fills both before full rises
//   reset clears position, run state, counters and both queues; a finish item
//   also returns the comparison state to its reset values
//   byte pairs past 65536 positions are dropped and flagged in the summary
// ----------------------------------------------------------------------------
module byte_stream_diff_ranges import bsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	// front to job queue
	logic   jq_push;
	job_t   jq_wr_job;
	logic   jq_full;

	// job queue to back
	job_t   jq_rd_job;
	logic   jq_empty;
	logic   jq_pop;

	// run tracking and job issue, one item per cycle while the job queue is not full
	bsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.jq_full (jq_full),
		.jq_push (jq_push),
		.jq_job  (jq_wr_job)
	);

	// decouples item intake from result generation
	bsd_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (jq_push),
		.wr_job (jq_wr_job),
		.full   (jq_full),
		.pop    (jq_pop),
		.empty  (jq_empty),
		.rd_job (jq_rd_job)
	);

	// one result item per cycle into the output queue while it has room and a job waits
	bsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (jq_empty),
		.job       (jq_rd_job),
		.jq_pop    (jq_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== src/bsd_checker.sv =====
// ----------------------------------------------------------------------------
// bsd_checker
// port level checks of the byte stream diff range block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsd_checker import bsd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	logic shown;
	logic held;
	logic is_sum, is_tail, is_eq, is_ident;
	logic tail_ok, eq_ok, ident_ok;

	assign shown    = !empty;
	assign held     = shown && !pop;
	assign is_sum   = shown && result.result_kind == KIND_SUMMARY;
	assign is_tail  = shown && result.result_kind == KIND_SIZE;
	assign is_eq    = shown && result.result_kind == KIND_EQUAL;
	assign is_ident = is_sum && result.identical;
	assign tail_ok  = !result.last_result && result.differing_count == '0;
	assign eq_ok    = result.region == REGION_0 && !result.identical;
	assign ident_ok = result.differing_count == '0 && result.first_diff == '0
		&& result.last_diff == '0;

	`CHK_NEXT(a_result_holds, clk, arst_n, held, shown && $stable(result), "result moved")
	`CHK_IMPL(a_summary_last, clk, arst_n, is_sum, result.last_result, "summary not last")
	`CHK_IMPL(a_tail_not_last, clk, arst_n, is_tail, tail_ok, "bad size range")
	`CHK_IMPL(a_equal_region, clk, arst_n, is_eq, eq_ok, "bad equal range")
	`CHK_IMPL(a_identical_zero, clk, arst_n, is_ident, ident_ok, "bad identical summary")

endmodule

bind byte_stream_diff_ranges bsd_checker u_bsd_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the byte stream diff range block
// ----------------------------------------------------------------------------
// a directed table covers extremes of sizes, saturation, every result kind
// and all four bank regions. Random image pairs with runs of equal and
// differing bytes follow under four idle/stall mixes.
// Every accepted item runs through a local model of the block, and every
// popped result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bsd_pkg::*;

	localparam int NO_TYPED = -1;         // row is checked against the model
	localparam int CYCLE_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 56;

	// one row of the directed part: the item and, where typed in, its results
	typedef struct {
		item_t   it;
		int      n_typed;
		result_t exp0;
		result_t exp1;
		result_t exp2;
	} directed_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item_in = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	// results still owed by the block, oldest first
	result_t pending_results[$];
	// per accepted item: count of typed results (or NO_TYPED), and the results
	int      typed_count_q[$];
	result_t typed_result_q[$];

	// model state
	logic [16:0] m_pos;
	logic        m_in_diff;
	logic        m_in_equal;
	logic [15:0] m_run_start;
	logic [16:0] m_diff_total;
	logic [15:0] m_first;
	logic [15:0] m_last;
	logic        m_ovf;
	result_t     model_out[3];
	int          model_n;

	int send_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int results_checked = 0;
	int error_count = 0;
	int cycles = 0;
	int kind_seen[4] = '{0, 0, 0, 0};

	byte_stream_diff_ranges DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item_in),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still owed", $time,
				cycles, pending_results.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// receiver: pop is redrawn every cycle, stall_pct of a hundred stay low
	always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

	// ---------------------------------------------------------------- model

	// bank of an offset: banks 0 to 2 span 0x2000 each, bank 3 the rest; top three bits pick it
	function automatic logic [1:0] bank_region(logic [15:0] off);
		unique case (off[15:13])
			3'd0: return REGION_0;
			3'd1: return REGION_1;
			3'd2: return REGION_2;
			default: return REGION_3;
		endcase
	endfunction

	function automatic result_t rng_res(logic [1:0] kind, logic [15:0] s, logic [15:0] e,
			logic [1:0] region, logic last);
		result_t r;
		r = '0;
		r.result_kind = kind;
		r.range_start = s;
		r.range_end = e;
		r.region = region;
		r.last_result = last;
		return r;
	endfunction

	function automatic result_t sum_res(logic ident, logic [16:0] dc, logic [16:0] ec,
			logic [15:0] fd, logic [15:0] ld, logic ovf);
		result_t r;
		r = '0;
		r.result_kind = KIND_SUMMARY;
		r.identical = ident;
		r.differing_count = dc;
		r.equal_count = ec;
		r.first_diff = fd;
		r.last_diff = ld;
		r.overflow = ovf;
		r.last_result = 1'b1;
		return r;
	endfunction

	// range item from the model; equal ranges carry no region
	function automatic void emit_range(logic [1:0] kind, int unsigned s, int unsigned e);
		logic [15:0] s16;
		s16 = s[15:0];
		model_out[model_n] = rng_res(kind, s16, e[15:0],
			(kind == KIND_EQUAL) ? REGION_0 : bank_region(s16), 1'b0);
		model_n++;
	endfunction

	function automatic void clear_compare_state();
		m_pos = '0;
		m_in_diff = 1'b0;
		m_in_equal = 1'b0;
		m_run_start = '0;
		m_diff_total = '0;
		m_first = '0;
		m_last = '0;
		m_ovf = 1'b0;
	endfunction

	// advance the model by one accepted item, results land in model_out
	function automatic void diff_model_step(item_t it);
		int unsigned ls, rs, lo, hi, differing, equal_n, first_o, last_o;
		model_n = 0;
		if (it.cmd == CMD_CMP) begin
			// past capacity: dropped, only flagged
			if (m_pos >= MAX_POS) begin
				m_ovf = 1'b1;
				return;
			end
			if (it.left_byte != it.right_byte) begin
				if (m_diff_total == '0) m_first = m_pos[15:0];
				m_last = m_pos[15:0];
				if (m_diff_total != CNT_SAT) m_diff_total++;
				if (m_in_equal) begin
					emit_range(KIND_EQUAL, 32'(m_run_start), 32'(m_pos) - 1);
					m_in_equal = 1'b0;
				end
				if (!m_in_diff) begin
					m_in_diff = 1'b1;
					m_run_start = m_pos[15:0];
				end
			end else begin
				if (m_in_diff) begin
					emit_range(KIND_DIFF, 32'(m_run_start), 32'(m_pos) - 1);
					m_in_diff = 1'b0;
				end
				if (!m_in_equal) begin
					m_in_equal = 1'b1;
					m_run_start = m_pos[15:0];
				end
			end
			m_pos++;
			if (model_n != 0) model_out[0].last_result = 1'b1;
		end else begin
			// oversized lengths clamp to capacity
			ls = (it.left_size > MAX_LEN) ? MAX_LEN : 32'(it.left_size);
			rs = (it.right_size > MAX_LEN) ? MAX_LEN : 32'(it.right_size);
			lo = (ls < rs) ? ls : rs;
			hi = (ls < rs) ? rs : ls;
			// open run closes at the last compared byte, whatever the sizes say
			if (m_pos > 0 && (m_in_diff || m_in_equal))
				emit_range(m_in_diff ? KIND_DIFF : KIND_EQUAL, 32'(m_run_start),
					32'(m_pos) - 1);
			differing = 32'(m_diff_total);
			first_o = 32'(m_first);
			last_o = 32'(m_last);
			if (ls != rs) begin
				emit_range(KIND_SIZE, lo, hi - 1);
				if (differing == 0) first_o = lo;
				last_o = hi - 1;
				differing += hi - lo;
			end
			if (differing > 32'(CNT_SAT)) differing = 32'(CNT_SAT);
			equal_n = (differing > hi) ? 32'd0 : hi - differing;
			model_out[model_n] = sum_res(differing == 0, differing[16:0], equal_n[16:0],
				(differing == 0) ? 16'h0 : first_o[15:0],
				(differing == 0) ? 16'h0 : last_o[15:0], m_ovf);
			model_n++;
			clear_compare_state();
		end
	endfunction

	// --------------------------------------------------------------- checking

	task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic compare_result(result_t want, result_t got);
		check_field("result_kind", 17'(want.result_kind), 17'(got.result_kind));
		check_field("range_start", 17'(want.range_start), 17'(got.range_start));
		check_field("range_end", 17'(want.range_end), 17'(got.range_end));
		check_field("region", 17'(want.region), 17'(got.region));
		check_field("identical", 17'(want.identical), 17'(got.identical));
		check_field("differing_count", want.differing_count, got.differing_count);
		check_field("equal_count", want.equal_count, got.equal_count);
		check_field("first_diff", 17'(want.first_diff), 17'(got.first_diff));
		check_field("last_diff", 17'(want.last_diff), 17'(got.last_diff));
		check_field("overflow", 17'(want.overflow), 17'(got.overflow));
		check_field("last_result", 17'(want.last_result), 17'(got.last_result));
	endtask

	// both handshakes are sampled at the edge, before any driver update lands
	always @(posedge clk) begin
		int n;
		if (arst_n) begin
			if (push && !full) begin
				n = typed_count_q.pop_front();
				diff_model_step(item_in);
				// typed rows take their written-out results, the model still advances
				if (n == NO_TYPED)
					for (int i = 0; i < model_n; i++)
						pending_results.insert(pending_results.size(), model_out[i]);
				else
					for (int i = 0; i < n; i++)
						pending_results.insert(pending_results.size(),
							typed_result_q.pop_front());
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none got %h", $time, result);
					error_count++;
				end else begin
					compare_result(pending_results.pop_front(), result);
					results_checked++;
					kind_seen[result.result_kind]++;
				end
			end
		end
	end

	// -------------------------------------------------------------- stimulus

	function automatic directed_row_t row(item_t it, int n, result_t a = '0,
			result_t b = '0, result_t c = '0);
		directed_row_t r;
		r.it = it;
		r.n_typed = n;
		r.exp0 = a;
		r.exp1 = b;
		r.exp2 = c;
		return r;
	endfunction

	function automatic item_t cmp_item(logic [7:0] l, logic [7:0] r);
		item_t it;
		it = '0;
		it.cmd = CMD_CMP;
		it.left_byte = l;
		it.right_byte = r;
		return it;
	endfunction

	function automatic item_t fin_item(logic [16:0] ls, logic [16:0] rs);
		item_t it;
		it = '0;
		it.cmd = CMD_FIN;
		it.left_size = ls;
		it.right_size = rs;
		return it;
	endfunction

	// compare item with random bytes; the unused size fields carry junk
	function automatic item_t byte_pair(bit is_diff);
		item_t it;
		logic [7:0] l;
		l = 8'($urandom_range(0, 255));
		it = cmp_item(l, is_diff ? l ^ 8'($urandom_range(1, 255)) : l);
		it.left_size = 17'($urandom_range(0, 17'h1FFFF));
		it.right_size = 17'($urandom_range(0, 17'h1FFFF));
		return it;
	endfunction

	task automatic send_item(input directed_row_t r);
		if (r.n_typed > 0) typed_result_q.insert(typed_result_q.size(), r.exp0);
		if (r.n_typed > 1) typed_result_q.insert(typed_result_q.size(), r.exp1);
		if (r.n_typed > 2) typed_result_q.insert(typed_result_q.size(), r.exp2);
		typed_count_q.insert(typed_count_q.size(), r.n_typed);
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		item_in <= r.it;
		push <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// sender holds off until every owed result has been popped
	task automatic hold_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// one random image pair: runs of equal and differing bytes, then a finish
	task automatic send_image_pair();
		int unsigned choice, len, sz_pick, k;
		logic [16:0] lsz, rsz;
		bit in_diff;
		item_t it;
		choice = $urandom_range(0, 19);
		if (choice == 0) begin
			// noise: unrelated items of either command, all fields random
			repeat ($urandom_range(1, 4)) begin
				it = byte_pair(1'($urandom_range(0, 1)));
				it.cmd = 1'($urandom_range(0, 1));
				send_item(row(it, NO_TYPED));
			end
		end else begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
			in_diff = 1'($urandom_range(0, 1));
			for (int p = 0; p < len; p++) begin
				if ($urandom_range(0, 3) == 0) in_diff = !in_diff;
				send_item(row(byte_pair(in_diff), NO_TYPED));
			end
			// broken sequence: no finish, the next pair continues the stream
			if (choice == 1) return;
			sz_pick = $urandom_range(0, 9);
			lsz = 17'(len);
			rsz = 17'(len);
			if (sz_pick >= 6 && sz_pick <= 7) begin
				// one image longer: size tail range
				k = $urandom_range(1, 30);
				if ($urandom_range(0, 1)) lsz = 17'(len + k);
				else rsz = 17'(len + k);
			end else if (sz_pick == 8) begin
				lsz = 17'($urandom_range(0, 17'h1FFFF));
				rsz = 17'($urandom_range(0, 17'h1FFFF));
			end else if (sz_pick == 9) begin
				// sizes that disagree with what was streamed
				lsz = 17'($urandom_range(0, len + 5));
				rsz = 17'($urandom_range(0, len + 5));
			end
			it = fin_item(lsz, rsz);
			it.left_byte = 8'($urandom_range(0, 255));
			it.right_byte = 8'($urandom_range(0, 255));
			send_item(row(it, NO_TYPED));
		end
	endtask

	// ------------------------------------------------------------------ main

	initial begin
		directed_row_t directed_rows[$];
		int phase_end;

		clear_compare_state();

		// finish straight after reset: nothing compared, identical
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd0, 17'd0), 1,
			sum_res(1'b1, 17'd0, 17'd0, 16'h0, 16'h0, 1'b0)));
		// byte extremes; an equal run 0..1 closes when the first difference comes
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h00, 8'h00), 0));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'hFF, 8'hFF), 0));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h00, 8'hFF), 1,
			rng_res(KIND_EQUAL, 16'd0, 16'd1, REGION_0, 1'b1)));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'hFF, 8'h00), 0));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'hAA, 8'h55), 0));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h5A, 8'h5A), 1,
			rng_res(KIND_DIFF, 16'd2, 16'd4, REGION_0, 1'b1)));
		// finish closes the open equal run, then the summary
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd6, 17'd6), 2,
			rng_res(KIND_EQUAL, 16'd5, 16'd5, REGION_0, 1'b0),
			sum_res(1'b0, 17'd3, 17'd3, 16'd2, 16'd4, 1'b0)));
		// oversized lengths clamp to capacity and then agree
		directed_rows.insert(directed_rows.size(), row(fin_item(17'h10000, 17'h1FFFF), 1,
			sum_res(1'b1, 17'd0, 17'h10000, 16'h0, 16'h0, 1'b0)));
		// three result kinds from one finish
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h01, 8'h02), 0));
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd3, 17'd1), 3,
			rng_res(KIND_DIFF, 16'd0, 16'd0, REGION_0, 1'b0),
			rng_res(KIND_SIZE, 16'd1, 16'd2, REGION_0, 1'b0),
			sum_res(1'b0, 17'd3, 17'd0, 16'd0, 16'd2, 1'b0)));
		// widest size tail, whole address space differs
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd0, 17'h10000), 2,
			rng_res(KIND_SIZE, 16'h0, 16'hFFFF, REGION_0, 1'b0),
			sum_res(1'b0, 17'h10000, 17'd0, 16'h0, 16'hFFFF, 1'b0)));
		// tail starting in the top bank
		directed_rows.insert(directed_rows.size(), row(fin_item(17'h1FFFF, 17'h7000), 2,
			rng_res(KIND_SIZE, 16'h7000, 16'hFFFF, REGION_3, 1'b0),
			sum_res(1'b0, 17'h9000, 17'h7000, 16'h7000, 16'hFFFF, 1'b0)));
		// tails in the middle banks
		directed_rows.insert(directed_rows.size(), row(fin_item(17'h2000, 17'h3000), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(fin_item(17'h5000, 17'h4000), NO_TYPED));
		// more differences than the sizes allow: equal count floors at zero
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h12, 8'h34), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h56, 8'h78), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h9A, 8'hBC), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'hDE, 8'hF0), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd1, 17'd1), NO_TYPED));
		// stream shorter than the stated sizes
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h33, 8'h33), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h44, 8'h45), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd8, 17'd0), NO_TYPED));
		// stream longer than the stated sizes
		directed_rows.insert(directed_rows.size(), row(cmp_item(8'h77, 8'h77), NO_TYPED));
		directed_rows.insert(directed_rows.size(), row(fin_item(17'd0, 17'd0), NO_TYPED));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_item(directed_rows[i]);
		hold_until_drained();

		// random image pairs: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_pct = 53;
					stall_pct = 0;
				end
				2: begin
					send_pct = 0;
					stall_pct = 53;
				end
				default: begin
					send_pct = 15;
					stall_pct = 15;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) send_image_pair();
			hold_until_drained();
		end

		// anything popped now is unexpected and is flagged as an error
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count += pending_results.size();
		end

		$display("covered %0d items and %0d results (diff %0d, equal %0d, size %0d, summary %0d)",
			items_sent, results_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("incl. directed extremes and random image pairs in four idle mixes, %0d errors",
			error_count);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/bsd_pkg.sv
src/bsd_front.sv
src/bsd_job_q.sv
src/bsd_back.sv
src/byte_stream_diff_ranges.sv
src/bsd_checker.sv
tb/testbench.sv
